FILE: rtl/vta_pkg.sv
// Shared types, constants and the arctangent table for the direction-to-angles pipeline.
package vta_pkg;

    // CORDIC datapath: scaled components are 32-bit, plus gain growth and negation headroom.
    localparam int CW = 36;
    // Angle accumulator in 2^-16 degree.
    localparam int AW = 26;
    localparam int ACC_FRAC = 16;
    localparam int ATAN_LEN = 24;

    // Horizontal length: 64-bit radicand, 32-bit root, one root bit per stage.
    localparam int RAD_W = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W = 36;
    localparam int SQ_STEPS = 32;

    localparam int DEG_90 = 90;
    localparam int DEG_270 = 270;
    localparam int DEG_360 = 360;

    typedef logic signed [CW-1:0] cdata_t;
    typedef logic signed [AW-1:0] acc_t;

    // 180 degrees in accumulator units
    localparam acc_t ACC_HALF_TURN = 26'sd11796480;

    typedef struct packed {
        logic zero_h;
        logic z_pos;
    } flags_t;

    // Payload carried alongside the yaw CORDIC
    typedef struct packed {
        logic [RAD_W-1:0] rad;
        cdata_t           zs;
        flags_t           flags;
    } yaw_side_t;

    // Payload carried alongside the square root
    typedef struct packed {
        acc_t   yaw_acc;
        cdata_t zs;
        flags_t flags;
    } sqrt_side_t;

    // Payload carried alongside the pitch CORDIC
    typedef struct packed {
        acc_t   yaw_acc;
        flags_t flags;
    } pitch_side_t;

    typedef struct packed {
        logic [15:0] yaw;
        logic [15:0] pitch;
    } result_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic acc_t atan_tab(input logic [4:0] idx);
        acc_t v;
        case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/vta_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per register stage, with a side payload.
module vta_cordic #(
    parameter int STEPS  = 16,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  vta_pkg::cdata_t     in_x,
    input  vta_pkg::cdata_t     in_y,
    input  vta_pkg::acc_t       in_acc,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output vta_pkg::acc_t       out_acc,
    output logic [SIDE_W-1:0]   out_side
);

    vta_pkg::cdata_t   x_reg     [0:STEPS-2];
    vta_pkg::cdata_t   y_reg     [0:STEPS-2];
    vta_pkg::acc_t     acc_reg   [0:STEPS-1];
    logic [SIDE_W-1:0] side_reg  [0:STEPS-1];
    logic              valid_reg [0:STEPS-1];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        vta_pkg::cdata_t   x_src;
        vta_pkg::cdata_t   y_src;
        vta_pkg::acc_t     acc_src;
        logic [SIDE_W-1:0] side_src;
        logic              valid_src;
        vta_pkg::acc_t     acc_next;

        if (i == 0)
        begin : g_first
            assign x_src     = in_x;
            assign y_src     = in_y;
            assign acc_src   = in_acc;
            assign side_src  = in_side;
            assign valid_src = in_valid;
        end
        else
        begin : g_rest
            assign x_src     = x_reg[i-1];
            assign y_src     = y_reg[i-1];
            assign acc_src   = acc_reg[i-1];
            assign side_src  = side_reg[i-1];
            assign valid_src = valid_reg[i-1];
        end

        // rotate toward y = 0: clockwise while y is non-negative
        assign acc_next = y_src[vta_pkg::CW-1] ? acc_src - vta_pkg::atan_tab(5'(i))
                                               : acc_src + vta_pkg::atan_tab(5'(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[i]  <= acc_next;
                side_reg[i] <= side_src;
            end
        end

        if (i < STEPS - 1)
        begin : g_xy
            vta_pkg::cdata_t x_next;
            vta_pkg::cdata_t y_next;

            assign x_next = y_src[vta_pkg::CW-1] ? x_src - (y_src >>> i) : x_src + (y_src >>> i);
            assign y_next = y_src[vta_pkg::CW-1] ? y_src + (x_src >>> i) : y_src - (x_src >>> i);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_acc   = acc_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

FILE: rtl/vta_sqrt.sv
// Pipelined restoring integer square root, one root bit per register stage.
module vta_sqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [vta_pkg::RAD_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [vta_pkg::ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int N = vta_pkg::SQ_STEPS;

    logic [vta_pkg::REM_W-1:0]  rem_reg   [0:N-2];
    logic [vta_pkg::RAD_W-1:0]  rad_reg   [0:N-2];
    logic [vta_pkg::ROOT_W-1:0] root_reg  [0:N-1];
    logic [SIDE_W-1:0]          side_reg  [0:N-1];
    logic                       valid_reg [0:N-1];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [vta_pkg::REM_W-1:0]  rem_src;
        logic [vta_pkg::RAD_W-1:0]  rad_src;
        logic [vta_pkg::ROOT_W-1:0] root_src;
        logic [SIDE_W-1:0]          side_src;
        logic                       valid_src;
        logic [vta_pkg::REM_W-1:0]  cand;
        logic [vta_pkg::REM_W-1:0]  trial;
        logic                       fits;

        if (k == 0)
        begin : g_first
            assign rem_src   = '0;
            assign rad_src   = in_rad;
            assign root_src  = '0;
            assign side_src  = in_side;
            assign valid_src = in_valid;
        end
        else
        begin : g_rest
            assign rem_src   = rem_reg[k-1];
            assign rad_src   = rad_reg[k-1];
            assign root_src  = root_reg[k-1];
            assign side_src  = side_reg[k-1];
            assign valid_src = valid_reg[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign cand  = {rem_src[vta_pkg::REM_W-3:0], rad_src[vta_pkg::RAD_W-1 -: 2]};
        assign trial = {2'b00, root_src, 2'b01};
        assign fits  = (cand >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_src[vta_pkg::ROOT_W-2:0], fits};
                side_reg[k] <= side_src;
            end
        end

        if (k < N - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= fits ? cand - trial : cand;
                    rad_reg[k] <= rad_src << 2;
                end
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

FILE: rtl/vta_outbuf.sv
// Output register with a skid entry; the pipeline enable comes from a register.
module vta_outbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  vta_pkg::result_t in_data,
    output logic             en,
    output logic             out_valid,
    input  logic             out_ready,
    output vta_pkg::result_t out_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    vta_pkg::result_t out_data_reg;
    vta_pkg::result_t skid_data_reg;
    logic             out_free;
    logic             take;
    logic             load_out_skid;
    logic             load_out_in;
    logic             load_skid;

    assign en       = !skid_valid_reg;
    assign take     = in_valid && en;
    assign out_free = !out_valid_reg || out_ready;

    assign load_out_skid = skid_valid_reg && out_free;
    assign load_out_in   = take && out_free;
    assign load_skid     = take && !out_free;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        skid_valid_next = skid_valid_reg;
        if (load_out_skid)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        else if (load_out_in)
        begin
            out_valid_next = 1'b1;
        end
        else if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
            out_data_reg <= skid_data_reg;
        else if (load_out_in)
            out_data_reg <= in_data;
        if (load_skid)
            skid_data_reg <= in_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // skid entry fills only behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output valid");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && in_valid))
        else $error("skid entry filled without a stalled output");

endmodule

FILE: rtl/vector_to_angles.sv
// Top level: direction vector (x, y, z) to yaw and pitch in 2^-ANGLE_FRAC_BITS degree.
//
// Input channel s_*: one transfer per direction vector, tdata = {dir_z, dir_y, dir_x}.
// Output channel m_*: one transfer per vector, tdata = {yaw, pitch}, each wrapped
// into [0, 360) degrees and rounded to nearest.
// Yaw = atan2(y, x) from a vectoring CORDIC; pitch = atan2(z, sqrt(x^2 + y^2)) from
// a second CORDIC fed by a bit-per-stage square root. A vector with zero x and y
// gives yaw 0 and pitch 90 degrees for positive z, else 270.
// Throughput: one vector per cycle, sustained, when m_tready stays high.
// Pipeline, from the input transfer to m_tvalid: two front stages (sign extend,
// square), CORDIC_STEPS yaw stages, 32 square-root stages, CORDIC_STEPS pitch
// stages, one rounding stage and the output register.
// Reset clears every valid bit; the pipeline comes up empty with s_tready high.
// When the receiver stalls, the output holds and one more result lands in a skid
// entry; s_tready then drops and the whole pipeline freezes in place until the
// output is taken. No vector is dropped or repeated.
module vector_to_angles #(
    parameter int COMPONENT_BITS  = 16,
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // pitch [15:0], yaw [31:16]
);

    localparam int CB         = COMPONENT_BITS;
    localparam int G          = 32 - CB;
    localparam int IN_W       = (CB > 16) ? CB : 16;
    localparam int SH         = vta_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int FULL_ANGLE = vta_pkg::DEG_360 * (1 << ANGLE_FRAC_BITS);
    localparam int UP_ANGLE   = vta_pkg::DEG_90 * (1 << ANGLE_FRAC_BITS);
    localparam int DOWN_ANGLE = vta_pkg::DEG_270 * (1 << ANGLE_FRAC_BITS);
    localparam logic [15:0] PITCH_UP   = UP_ANGLE[15:0];
    localparam logic [15:0] PITCH_DOWN = DOWN_ANGLE[15:0];
    localparam logic        FULL_FITS  = (FULL_ANGLE <= 65536);
    localparam vta_pkg::acc_t ROUND_HALF = vta_pkg::acc_t'(1 << (SH - 1));
    localparam vta_pkg::acc_t FULL_ACC   = vta_pkg::acc_t'(FULL_ANGLE);

    localparam int YSIDE_W = $bits(vta_pkg::yaw_side_t);
    localparam int SSIDE_W = $bits(vta_pkg::sqrt_side_t);
    localparam int PSIDE_W = $bits(vta_pkg::pitch_side_t);

    function automatic logic [15:0] finish_angle(input vta_pkg::acc_t acc);
        vta_pkg::acc_t a;
        a = (acc + ROUND_HALF) >>> SH;
        if (a < 0)
            a = a + FULL_ACC;
        if (a >= FULL_ACC)
            a = a - FULL_ACC;
        return a[15:0];
    endfunction

    logic en;

    // ---- stage 1: sign extend the components
    logic [IN_W-1:0]      ext_x;
    logic [IN_W-1:0]      ext_y;
    logic [IN_W-1:0]      ext_z;
    logic signed [CB-1:0] x1_reg;
    logic signed [CB-1:0] y1_reg;
    logic signed [CB-1:0] z1_reg;
    logic                 v1_reg;

    assign s_tready = en;
    assign ext_x = IN_W'(s_tdata[15:0]);
    assign ext_y = IN_W'(s_tdata[31:16]);
    assign ext_z = IN_W'(s_tdata[47:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= signed'(ext_x[CB-1:0]);
            y1_reg <= signed'(ext_y[CB-1:0]);
            z1_reg <= signed'(ext_z[CB-1:0]);
        end
    end

    // ---- stage 2: squares, yaw start vector, flags
    logic signed [2*CB-1:0] xx;
    logic signed [2*CB-1:0] yy;
    vta_pkg::cdata_t        xs_w;
    vta_pkg::cdata_t        ys_w;
    logic                   x_neg;
    logic [2*CB-1:0]        xx2_reg;
    logic [2*CB-1:0]        yy2_reg;
    vta_pkg::cdata_t        xs2_reg;
    vta_pkg::cdata_t        ys2_reg;
    vta_pkg::acc_t          acc2_reg;
    vta_pkg::cdata_t        zs2_reg;
    vta_pkg::flags_t        flags2_reg;
    logic                   v2_reg;

    assign xx    = x1_reg * x1_reg;
    assign yy    = y1_reg * y1_reg;
    assign xs_w  = vta_pkg::cdata_t'(x1_reg) <<< G;
    assign ys_w  = vta_pkg::cdata_t'(y1_reg) <<< G;
    assign x_neg = x1_reg[CB-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx2_reg          <= xx;
            yy2_reg          <= yy;
            // left half-plane: negate and start from 180 degrees
            xs2_reg          <= x_neg ? -xs_w : xs_w;
            ys2_reg          <= x_neg ? -ys_w : ys_w;
            acc2_reg         <= x_neg ? vta_pkg::ACC_HALF_TURN : '0;
            zs2_reg          <= vta_pkg::cdata_t'(z1_reg) <<< G;
            flags2_reg.zero_h <= (x1_reg == '0) && (y1_reg == '0);
            flags2_reg.z_pos  <= !z1_reg[CB-1] && (z1_reg != '0);
        end
    end

    // ---- yaw CORDIC, radicand rides along
    logic [2*CB-1:0]        hsum;
    vta_pkg::yaw_side_t     yside_in;
    logic [YSIDE_W-1:0]     yside_out;
    vta_pkg::yaw_side_t     yside;
    logic                   yv;
    vta_pkg::acc_t          yacc;

    assign hsum           = xx2_reg + yy2_reg;
    assign yside_in.rad   = vta_pkg::RAD_W'(hsum) << (2 * G);
    assign yside_in.zs    = zs2_reg;
    assign yside_in.flags = flags2_reg;

    vta_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (YSIDE_W)
    ) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_x      (xs2_reg),
        .in_y      (ys2_reg),
        .in_acc    (acc2_reg),
        .in_side   (yside_in),
        .out_valid (yv),
        .out_acc   (yacc),
        .out_side  (yside_out)
    );

    assign yside = vta_pkg::yaw_side_t'(yside_out);

    // ---- horizontal length
    vta_pkg::sqrt_side_t          sside_in;
    logic [SSIDE_W-1:0]           sside_out;
    vta_pkg::sqrt_side_t          sside;
    logic                         sv;
    logic [vta_pkg::ROOT_W-1:0]   root;

    assign sside_in.yaw_acc = yacc;
    assign sside_in.zs      = yside.zs;
    assign sside_in.flags   = yside.flags;

    vta_sqrt #(
        .SIDE_W (SSIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (yv),
        .in_rad    (yside.rad),
        .in_side   (sside_in),
        .out_valid (sv),
        .out_root  (root),
        .out_side  (sside_out)
    );

    assign sside = vta_pkg::sqrt_side_t'(sside_out);

    // ---- pitch CORDIC
    vta_pkg::pitch_side_t pside_in;
    logic [PSIDE_W-1:0]   pside_out;
    vta_pkg::pitch_side_t pside;
    logic                 pv;
    vta_pkg::acc_t        pacc;
    vta_pkg::cdata_t      len_x;

    assign pside_in.yaw_acc = sside.yaw_acc;
    assign pside_in.flags   = sside.flags;
    assign len_x            = vta_pkg::CW'(root);

    vta_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (PSIDE_W)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sv),
        .in_x      (len_x),
        .in_y      (sside.zs),
        .in_acc    ('0),
        .in_side   (pside_in),
        .out_valid (pv),
        .out_acc   (pacc),
        .out_side  (pside_out)
    );

    assign pside = vta_pkg::pitch_side_t'(pside_out);

    // ---- rounding, wrap and the vertical-vector case
    vta_pkg::result_t res_next;
    vta_pkg::result_t res_reg;
    logic             vres_reg;

    always_comb
    begin
        if (pside.flags.zero_h)
        begin
            res_next.yaw   = '0;
            res_next.pitch = pside.flags.z_pos ? PITCH_UP : PITCH_DOWN;
        end
        else
        begin
            res_next.yaw   = finish_angle(pside.yaw_acc);
            res_next.pitch = finish_angle(pacc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vres_reg <= 1'b0;
        else if (en)
            vres_reg <= pv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    vta_pkg::result_t out_data;

    vta_outbuf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vres_reg),
        .in_data   (res_reg),
        .en        (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data;

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && FULL_FITS) |-> ({1'b0, m_tdata[15:0]} < 17'(FULL_ANGLE)))
        else $error("pitch outside one turn");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && FULL_FITS) |-> ({1'b0, m_tdata[31:16]} < 17'(FULL_ANGLE)))
        else $error("yaw outside one turn");

endmodule

FILE: bench/vta_checker.sv
`timescale 1ns / 1ps
// Watches both streams of vector_to_angles, predicts yaw and pitch per vector and compares.
module vta_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // pitch [15:0], yaw [31:16]
    output int          bad_count,
    output int          pending
);

    localparam int  ANGLE_BITS = 7;
    localparam int  STEPS      = 16;
    localparam int  GUARD      = 16;
    localparam longint FULL_TURN = longint'(vta_pkg::DEG_360) << ANGLE_BITS;

    // atan(2^-i) in 2^-16 degree
    localparam longint ATAN_UNITS [0:15] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    vta_pkg::result_t angle_q[$];

    function automatic longint unsigned root64(longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Rotate (vx, vy) onto the x axis, accumulating the angle turned.
    function automatic longint rotate_to_axis(longint vx, longint vy, longint acc);
        longint dx;
        longint dy;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx = vx + dx;
                vy = vy - dy;
                acc = acc + ATAN_UNITS[i];
            end
            else
            begin
                vx = vx - dx;
                vy = vy + dy;
                acc = acc - ATAN_UNITS[i];
            end
        end
        return acc;
    endfunction

    // Round to nearest output unit, ties up, then wrap once into one turn.
    function automatic logic [15:0] to_angle_units(longint acc);
        longint a;
        a = (acc + (longint'(1) << (vta_pkg::ACC_FRAC - ANGLE_BITS - 1)))
            >>> (vta_pkg::ACC_FRAC - ANGLE_BITS);
        if (a < 0)
            a = a + FULL_TURN;
        if (a >= FULL_TURN)
            a = a - FULL_TURN;
        return a[15:0];
    endfunction

    function automatic vta_pkg::result_t predict_angles(logic [47:0] vec);
        vta_pkg::result_t r;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint yaw_acc;
        longint unsigned sq;
        longint len;
        x = longint'($signed(vec[15:0]));
        y = longint'($signed(vec[31:16]));
        z = longint'($signed(vec[47:32]));
        if (x == 0 && y == 0)
        begin
            r.yaw = 16'd0;
            r.pitch = (z > 0) ? 16'(vta_pkg::DEG_90 << ANGLE_BITS)
                              : 16'(vta_pkg::DEG_270 << ANGLE_BITS);
            return r;
        end
        xs = x <<< GUARD;
        ys = y <<< GUARD;
        yaw_acc = 0;
        // Fold the left half plane over and start from half a turn.
        if (xs < 0)
        begin
            xs = -xs;
            ys = -ys;
            yaw_acc = longint'(180) << vta_pkg::ACC_FRAC;
        end
        yaw_acc = rotate_to_axis(xs, ys, yaw_acc);
        sq = (longint'(x * x) + longint'(y * y));
        sq = sq << (2 * GUARD);
        len = longint'(root64(sq));
        r.yaw = to_angle_units(yaw_acc);
        r.pitch = to_angle_units(rotate_to_axis(len, z <<< GUARD, 0));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vta_pkg::result_t got;
        vta_pkg::result_t want;
        if (!rst_n)
        begin
            angle_q.delete();
            bad_count = 0;
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                angle_q.push_back(predict_angles(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (angle_q.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("checker: unexpected transfer pitch=%0d yaw=%0d",
                                 got.pitch, got.yaw);
                end
                else
                begin
                    want = angle_q.pop_front();
                    if (got.pitch !== want.pitch || got.yaw !== want.yaw)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("checker: mismatch pitch exp=%0d got=%0d, %s%0d got=%0d",
                                     want.pitch, got.pitch, "yaw exp=", want.yaw, got.yaw);
                    end
                end
            end
            pending = angle_q.size();
        end
    end

endmodule

FILE: bench/tb_vector_to_angles.sv
`timescale 1ns / 1ps
// Testbench top for vector_to_angles: clock, reset, stimulus, back-pressure and verdict.
module tb_vector_to_angles;

    localparam int RANDOM_VECTORS = 800;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          bad_count;
    int          pending;
    int          send_idle = 0;
    int          recv_idle = 0;

    always #5 clk = ~clk;

    vector_to_angles u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    vta_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .bad_count (bad_count),
        .pending   (pending)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Hold the input idle until every result in flight has been taken.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_component();
        logic [15:0] v;
        case ($urandom_range(5))
            0, 1, 2: v = 16'($urandom);
            3:       v = 16'($urandom_range(8)) - 16'd4;
            4:       v = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
            default: v = ($urandom_range(1) != 0) ? 16'($urandom_range(300))
                                                  : -16'($urandom_range(300));
        endcase
        return v;
    endfunction

    initial
    begin
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero horizontal part, all signs of z including zero
        send_vector(16'd0, 16'd0, 16'd0);
        send_vector(16'd0, 16'd0, 16'd1);
        send_vector(16'd0, 16'd0, 16'hFFFF);
        send_vector(16'd0, 16'd0, 16'h7FFF);
        send_vector(16'd0, 16'd0, 16'h8000);
        // Level vectors along each axis and the extremes
        send_vector(16'h7FFF, 16'd0, 16'd0);
        send_vector(16'h8000, 16'd0, 16'd0);
        send_vector(16'd0, 16'h7FFF, 16'd0);
        send_vector(16'd0, 16'h8000, 16'd0);
        send_vector(16'hFFFF, 16'd0, 16'd0);
        send_vector(16'd1, 16'd1, 16'd0);
        send_vector(16'h7FFF, 16'hFFFF, 16'd0);
        send_vector(16'h8000, 16'd1, 16'd0);
        send_vector(16'h8000, 16'hFFFF, 16'd0);
        // Steep and corner vectors
        send_vector(16'd1, 16'd0, 16'h7FFF);
        send_vector(16'd1, 16'd0, 16'h8000);
        send_vector(16'h8000, 16'h8000, 16'h8000);
        send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vector(16'h8000, 16'h8000, 16'h7FFF);
        send_vector(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_vector(16'h5555, 16'hAAAA, 16'h5555);
        send_vector(16'hAAAA, 16'h5555, 16'hAAAA);
        drain_pipeline();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 37 : (phase == 1) ? 46 : 0;
            recv_idle = (phase == 0) ? 46 : (phase == 1) ? 37 : 0;
            for (int n = 0; n < RANDOM_VECTORS / 3; n++)
            begin
                x = pick_component();
                y = pick_component();
                z = pick_component();
                if ($urandom_range(9) == 0)
                begin
                    x = 16'd0;
                    y = 16'd0;
                end
                send_vector(x, y, z);
                if (phase == 1 && n == 100)
                    drain_pipeline();
            end
        end

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (80) @(posedge clk);
        if (bad_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
